// ===== rtl/htca_pkg.sv =====
// package for the humidity and temperature conversion and averaging block
package htca_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_NUM,
    ST_DIV_HUM,
    ST_HUM_SIGN,
    ST_ACCUM,
    ST_DIV_TAVG,
    ST_DIV_HAVG,
    ST_DONE
  } htca_state_t;

  // field widths
  localparam int RAW_TEMP_W = 14;
  localparam int RAW_HUM_W  = 12;
  localparam int OUT_W      = 15;
  localparam int WIN_W      = 8;
  localparam int SUM_W      = 24;
  localparam int NUM_W      = 34;
  localparam int CNT_W      = 5;
  localparam int MUL_W      = 28;

  // window limit and reset value
  localparam logic [15:0]      MAX_WINDOW    = 16'd255;
  localparam logic [WIN_W-1:0] WINDOW_RESET  = 8'd3;

  // humidity constants scaled by 1e7 (HUM_CT by 1e5), temperature constants in hundredths
  localparam logic signed [19:0]      HUM_C1      = 20'sd405000;
  localparam logic signed [16:0]      HUM_CT      = 17'sd1000;
  localparam logic signed [19:0]      TEMP_REF    = 20'sd6460;
  localparam logic signed [NUM_W-1:0] HUM_OFFSET  = -34'sd40000000;
  localparam logic signed [OUT_W-1:0] TEMP_OFFSET = 15'sd3960;

  // humidity divide by 1e5: drop 2^5, then multiply by ceil(2^38 / 3125) and keep bits 38 up
  localparam int HUM_PRE_SH   = 5;
  localparam int HUM_MAG_W    = 26;
  localparam int HUM_RECIP_SH = 38;
  localparam int HUM_Q_W      = 15;
  localparam logic signed [MUL_W-1:0] HUM_RECIP = 28'sd87960931;

  // average divider setup
  localparam int AVG_QBITS = SUM_W;

endpackage

// ===== rtl/humidity_temp_convert_average.sv =====
// top level: sensor linearization with block averaging on a shared multiplier and divider
//
// usage
//   input channel: in_valid / in_stall with in_raw_temp and in_raw_humidity; a
//   transaction takes place at a rising edge where in_valid is high and in_stall low
//   result channel: out_valid / out_stall with converted values, the ready flag and
//   the window averages; one result transaction per input transaction
//   configuration: cfg_wr_en / cfg_wr_data write the averaging window; the user must
//   write it only while idle, the block itself does not enforce this
// sequencing
//   one multiplier and one restoring divider step are reused by a small sequencer;
//   the humidity divide by 1e5 is a reciprocal product on the shared multiplier;
//   a sample runs through ST_MUL_A, ST_MUL_B, ST_NUM, ST_DIV_HUM, ST_HUM_SIGN and
//   ST_ACCUM, for a closing window then ST_DIV_TAVG and ST_DIV_HAVG (24 divider
//   steps each), then ST_DONE; in_stall is high while a sample is at work
// reset
//   rst_n low clears the sums, the sample count, the result valid and sets the
//   window to 3
// stalls
//   the result sits in an output register; a finished result may wait there while
//   the next sample is taken and converted, the sequencer waits only if a second
//   result is ready before the first is taken
module humidity_temp_convert_average (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [htca_pkg::RAW_TEMP_W-1:0]   in_raw_temp,
  input  logic [htca_pkg::RAW_HUM_W-1:0]    in_raw_humidity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [htca_pkg::OUT_W-1:0] out_temp_hundredths,
  output logic signed [htca_pkg::OUT_W-1:0] out_humidity_hundredths,
  output logic                              out_average_ready,
  output logic signed [htca_pkg::OUT_W-1:0] out_avg_temp_hundredths,
  output logic signed [htca_pkg::OUT_W-1:0] out_avg_humidity_hundredths,
  input  logic                              cfg_wr_en,
  input  logic [htca_pkg::WIN_W-1:0]        cfg_wr_data
);

  // control state
  htca_pkg::htca_state_t state_r, state_nxt;
  logic [htca_pkg::WIN_W-1:0]        window_r;
  logic signed [htca_pkg::SUM_W-1:0] temp_sum_r, temp_sum_nxt;
  logic signed [htca_pkg::SUM_W-1:0] hum_sum_r, hum_sum_nxt;
  logic [htca_pkg::WIN_W-1:0]        count_r, count_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // working registers
  logic [htca_pkg::RAW_TEMP_W-1:0]   t_r, t_nxt;
  logic [htca_pkg::RAW_HUM_W-1:0]    h_r, h_nxt;
  logic signed [htca_pkg::NUM_W-1:0] prod_r, prod_nxt;
  logic signed [htca_pkg::NUM_W-1:0] acc_r, acc_nxt;
  logic signed [htca_pkg::OUT_W-1:0] temp_r, temp_nxt;
  logic signed [15:0]                hum_r, hum_nxt;
  logic                              ready_r, ready_nxt;
  logic signed [htca_pkg::OUT_W-1:0] avg_t_r, avg_t_nxt;
  logic signed [htca_pkg::OUT_W-1:0] avg_h_r, avg_h_nxt;

  // shared divider registers
  logic [htca_pkg::NUM_W-1:0]        div_rem_r, div_rem_nxt;
  logic [htca_pkg::NUM_W-1:0]        div_den_r, div_den_nxt;
  logic [htca_pkg::SUM_W-1:0]        div_quo_r, div_quo_nxt;
  logic [htca_pkg::CNT_W-1:0]        div_cnt_r, div_cnt_nxt;
  logic                              div_neg_r, div_neg_nxt;

  // output payload registers
  logic signed [htca_pkg::OUT_W-1:0] o_temp_r, o_temp_nxt;
  logic signed [htca_pkg::OUT_W-1:0] o_hum_r, o_hum_nxt;
  logic                              o_ready_r, o_ready_nxt;
  logic signed [htca_pkg::OUT_W-1:0] o_avg_t_r, o_avg_t_nxt;
  logic signed [htca_pkg::OUT_W-1:0] o_avg_h_r, o_avg_h_nxt;
  logic                              out_load;

  // shared multiplier
  logic signed [htca_pkg::MUL_W-1:0]   mul_x;
  logic signed [htca_pkg::MUL_W-1:0]   mul_y;
  logic signed [2*htca_pkg::MUL_W-1:0] mul_p;

  // operand shaping for the two products
  logic signed [19:0] coef_a;
  logic signed [19:0] t_off;
  logic signed [16:0] coef_b;
  logic signed [htca_pkg::NUM_W-1:0] num;

  // divider step
  logic                       div_ge;
  logic [htca_pkg::SUM_W-1:0] quo_step;
  logic [htca_pkg::SUM_W-1:0] quo_res;

  // divider load
  logic                              div_load;
  logic                              ld_neg;
  logic [htca_pkg::NUM_W-1:0]        ld_mag;
  logic [htca_pkg::NUM_W-1:0]        ld_den;
  logic [htca_pkg::CNT_W-1:0]        ld_cnt;

  // window handling
  logic [htca_pkg::WIN_W-1:0]        w_eff;
  logic [htca_pkg::WIN_W:0]          count_inc;
  logic                              win_done;
  logic signed [htca_pkg::SUM_W-1:0] temp_sum_add;
  logic signed [htca_pkg::SUM_W-1:0] hum_sum_add;

  assign in_stall = (state_r != htca_pkg::ST_IDLE);

  // 405000 - 28h, with 28h as 32h - 4h
  assign coef_a = htca_pkg::HUM_C1 - $signed({3'b000, h_r, 5'b00000})
                  + $signed({6'b000000, h_r, 2'b00});
  assign t_off  = $signed({6'b000000, t_r}) - htca_pkg::TEMP_REF;
  assign coef_b = htca_pkg::HUM_CT + $signed({2'b00, h_r, 3'b000});

  // operand select: quadratic term, compensation term, or reciprocal of 3125
  always_comb begin
    case (state_r)
      htca_pkg::ST_MUL_A: begin
        mul_x = htca_pkg::MUL_W'(coef_a);
        mul_y = $signed({16'b0, h_r});
      end
      htca_pkg::ST_DIV_HUM: begin
        mul_x = $signed({2'b00, div_rem_r[htca_pkg::HUM_PRE_SH +: htca_pkg::HUM_MAG_W]});
        mul_y = htca_pkg::HUM_RECIP;
      end
      default: begin
        mul_x = htca_pkg::MUL_W'(t_off);
        mul_y = htca_pkg::MUL_W'(coef_b);
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // full humidity numerator over 1e5
  assign num = acc_r + prod_r;

  // restoring division for the averages, one quotient bit per cycle
  assign div_ge   = (div_rem_r >= div_den_r);
  assign quo_step = {div_quo_r[htca_pkg::SUM_W-2:0], div_ge};
  assign quo_res  = div_neg_r ? (~quo_step + 1'b1) : quo_step;

  // effective window: zero acts as one, clamp to the limit
  always_comb begin
    if (window_r == '0) begin
      w_eff = 8'd1;
    end else if ({8'b0, window_r} > htca_pkg::MAX_WINDOW) begin
      w_eff = htca_pkg::MAX_WINDOW[htca_pkg::WIN_W-1:0];
    end else begin
      w_eff = window_r;
    end
  end

  assign count_inc    = {1'b0, count_r} + 1'b1;
  assign win_done     = (count_inc >= {1'b0, w_eff});
  assign temp_sum_add = temp_sum_r + htca_pkg::SUM_W'(temp_r);
  assign hum_sum_add  = hum_sum_r + htca_pkg::SUM_W'(hum_r);

  // result register is free when empty or being taken this cycle
  assign out_load = (state_r == htca_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    temp_sum_nxt  = temp_sum_r;
    hum_sum_nxt   = hum_sum_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    ready_nxt     = ready_r;
    avg_t_nxt     = avg_t_r;
    avg_h_nxt     = avg_h_r;
    o_temp_nxt    = o_temp_r;
    o_hum_nxt     = o_hum_r;
    o_ready_nxt   = o_ready_r;
    o_avg_t_nxt   = o_avg_t_r;
    o_avg_h_nxt   = o_avg_h_r;
    div_load      = 1'b0;
    ld_neg        = 1'b0;
    ld_mag        = '0;
    ld_den        = '0;
    ld_cnt        = '0;

    // default divider step
    div_rem_nxt = div_ge ? (div_rem_r - div_den_r) : div_rem_r;
    div_den_nxt = div_den_r >> 1;
    div_quo_nxt = quo_step;
    div_cnt_nxt = div_cnt_r - 1'b1;
    div_neg_nxt = div_neg_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      htca_pkg::ST_IDLE: begin
        if (in_valid) begin
          t_nxt     = in_raw_temp;
          h_nxt     = in_raw_humidity;
          state_nxt = htca_pkg::ST_MUL_A;
        end
      end
      htca_pkg::ST_MUL_A: begin
        prod_nxt  = mul_p[htca_pkg::NUM_W-1:0];
        state_nxt = htca_pkg::ST_MUL_B;
      end
      htca_pkg::ST_MUL_B: begin
        acc_nxt   = prod_r + htca_pkg::HUM_OFFSET;
        prod_nxt  = mul_p[htca_pkg::NUM_W-1:0];
        temp_nxt  = $signed({1'b0, t_r}) - htca_pkg::TEMP_OFFSET;
        state_nxt = htca_pkg::ST_NUM;
      end
      htca_pkg::ST_NUM: begin
        // park the numerator magnitude and sign in the divider registers
        div_load  = 1'b1;
        ld_neg    = num[htca_pkg::NUM_W-1];
        ld_mag    = ld_neg ? (~num + 1'b1) : num;
        state_nxt = htca_pkg::ST_DIV_HUM;
      end
      htca_pkg::ST_DIV_HUM: begin
        // magnitude / 1e5 truncated, from the reciprocal product
        prod_nxt  = htca_pkg::NUM_W'(mul_p[htca_pkg::HUM_RECIP_SH +: htca_pkg::HUM_Q_W]);
        state_nxt = htca_pkg::ST_HUM_SIGN;
      end
      htca_pkg::ST_HUM_SIGN: begin
        hum_nxt   = div_neg_r ? (~prod_r[15:0] + 1'b1) : prod_r[15:0];
        state_nxt = htca_pkg::ST_ACCUM;
      end
      htca_pkg::ST_ACCUM: begin
        temp_sum_nxt = temp_sum_add;
        hum_sum_nxt  = hum_sum_add;
        ready_nxt    = win_done;
        if (win_done) begin
          count_nxt = '0;
          div_load  = 1'b1;
          ld_neg    = temp_sum_add[htca_pkg::SUM_W-1];
          ld_mag    = {10'b0, ld_neg ? (~temp_sum_add + 1'b1) : temp_sum_add};
          ld_den    = {3'b000, w_eff, 23'b0};
          ld_cnt    = htca_pkg::CNT_W'(htca_pkg::AVG_QBITS - 1);
          state_nxt = htca_pkg::ST_DIV_TAVG;
        end else begin
          count_nxt = count_inc[htca_pkg::WIN_W-1:0];
          avg_t_nxt = '0;
          avg_h_nxt = '0;
          state_nxt = htca_pkg::ST_DONE;
        end
      end
      htca_pkg::ST_DIV_TAVG: begin
        if (div_cnt_r == '0) begin
          avg_t_nxt = quo_res[htca_pkg::OUT_W-1:0];
          div_load  = 1'b1;
          ld_neg    = hum_sum_r[htca_pkg::SUM_W-1];
          ld_mag    = {10'b0, ld_neg ? (~hum_sum_r + 1'b1) : hum_sum_r};
          ld_den    = {3'b000, w_eff, 23'b0};
          ld_cnt    = htca_pkg::CNT_W'(htca_pkg::AVG_QBITS - 1);
          state_nxt = htca_pkg::ST_DIV_HAVG;
        end
      end
      htca_pkg::ST_DIV_HAVG: begin
        if (div_cnt_r == '0) begin
          avg_h_nxt    = quo_res[htca_pkg::OUT_W-1:0];
          // window closed, start a fresh block
          temp_sum_nxt = '0;
          hum_sum_nxt  = '0;
          state_nxt    = htca_pkg::ST_DONE;
        end
      end
      htca_pkg::ST_DONE: begin
        if (out_load) begin
          o_temp_nxt    = temp_r;
          o_hum_nxt     = hum_r[htca_pkg::OUT_W-1:0];
          o_ready_nxt   = ready_r;
          o_avg_t_nxt   = avg_t_r;
          o_avg_h_nxt   = avg_h_r;
          out_valid_nxt = 1'b1;
          state_nxt     = htca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = htca_pkg::ST_IDLE;
      end
    endcase

    if (div_load) begin
      div_rem_nxt = ld_mag;
      div_den_nxt = ld_den;
      div_quo_nxt = '0;
      div_cnt_nxt = ld_cnt;
      div_neg_nxt = ld_neg;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htca_pkg::ST_IDLE;
      window_r    <= htca_pkg::WINDOW_RESET;
      temp_sum_r  <= '0;
      hum_sum_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      temp_sum_r  <= temp_sum_nxt;
      hum_sum_r   <= hum_sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    h_r       <= h_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    temp_r    <= temp_nxt;
    hum_r     <= hum_nxt;
    ready_r   <= ready_nxt;
    avg_t_r   <= avg_t_nxt;
    avg_h_r   <= avg_h_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    div_quo_r <= div_quo_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_neg_r <= div_neg_nxt;
    o_temp_r  <= o_temp_nxt;
    o_hum_r   <= o_hum_nxt;
    o_ready_r <= o_ready_nxt;
    o_avg_t_r <= o_avg_t_nxt;
    o_avg_h_r <= o_avg_h_nxt;
  end

  assign out_valid                   = out_valid_r;
  assign out_temp_hundredths         = o_temp_r;
  assign out_humidity_hundredths     = o_hum_r;
  assign out_average_ready           = o_ready_r;
  assign out_avg_temp_hundredths     = o_avg_t_r;
  assign out_avg_humidity_hundredths = o_avg_h_r;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the humidity and temperature conversion and averaging block
module tb;

  // watchdog limit in cycles without any transaction on either channel
  localparam int QUIET_LIMIT   = 3000;
  // length of the long receiver hold-off that fills the block up
  localparam int HOLD_CYCLES   = 400;
  // cycles allowed after the last result before the verdict
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_PHASES    = 7;

  typedef logic [htca_pkg::RAW_TEMP_W-1:0] raw_temp_t;
  typedef logic [htca_pkg::RAW_HUM_W-1:0]  raw_hum_t;
  typedef logic [htca_pkg::OUT_W-1:0]      hundredths_t;

  // one result transaction as the block should present it
  typedef struct packed {
    hundredths_t temp;
    hundredths_t hum;
    logic        ready;
    hundredths_t avg_temp;
    hundredths_t avg_hum;
  } reading_t;

  // one row of the directed table: a window write or a sample, optionally with a typed result
  typedef struct packed {
    logic                       is_cfg;
    logic [htca_pkg::WIN_W-1:0] win;
    raw_temp_t                  t;
    raw_hum_t                   h;
    logic                       typed;
    reading_t                   want;
  } dir_row_t;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_SQUARE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  raw_temp_t   in_raw_temp = '0;
  raw_hum_t    in_raw_humidity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hundredths_t out_temp_hundredths;
  hundredths_t out_humidity_hundredths;
  logic        out_average_ready;
  hundredths_t out_avg_temp_hundredths;
  hundredths_t out_avg_humidity_hundredths;
  logic        cfg_wr_en = 1'b0;
  logic [htca_pkg::WIN_W-1:0] cfg_wr_data = '0;

  // predictor copy of the block's state and window register
  logic [htca_pkg::SUM_W-1:0] acc_temp;
  logic [htca_pkg::SUM_W-1:0] acc_hum;
  logic [htca_pkg::WIN_W-1:0] n_samples;
  logic [htca_pkg::WIN_W-1:0] win_cfg;

  reading_t expected_readings[$];
  dir_row_t dir_rows[$];

  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int windows_done = 0;
  int cfg_writes   = 0;
  int quiet_cycles = 0;

  // sender pacing
  int burst_left = 0;

  // receiver pattern state; a hold-off starts when hold_req_cnt moves past hold_seen
  int       hold_req_cnt = 0;
  int       hold_seen    = 0;
  int       hold_left    = 0;
  int       seg_left     = 0;
  rx_mode_t rx_mode      = RX_OPEN;

  humidity_temp_convert_average u_dut (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .in_valid                    (in_valid),
    .in_stall                    (in_stall),
    .in_raw_temp                 (in_raw_temp),
    .in_raw_humidity             (in_raw_humidity),
    .out_valid                   (out_valid),
    .out_stall                   (out_stall),
    .out_temp_hundredths         (out_temp_hundredths),
    .out_humidity_hundredths     (out_humidity_hundredths),
    .out_average_ready           (out_average_ready),
    .out_avg_temp_hundredths     (out_avg_temp_hundredths),
    .out_avg_humidity_hundredths (out_avg_humidity_hundredths),
    .cfg_wr_en                   (cfg_wr_en),
    .cfg_wr_data                 (cfg_wr_data)
  );

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: converts one sample, accumulates it and closes the window when due
  // ---------------------------------------------------------------------------
  function automatic reading_t convert_and_average(input raw_temp_t t, input raw_hum_t h);
    reading_t                   r;
    longint                     tv;
    longint                     hv;
    longint                     temp_c;
    longint                     num;
    longint                     hum_c;
    longint                     w;
    longint                     avg_t;
    longint                     avg_h;
    logic [htca_pkg::SUM_W-1:0] nt;
    logic [htca_pkg::SUM_W-1:0] nh;
    tv = t;
    hv = h;
    // temperature is an exact offset of the raw reading
    temp_c = tv - 3960;
    // humidity as one exact numerator over 1e5, truncated toward zero
    num = -40000000 + 405000 * hv - 28 * hv * hv + (tv - 6460) * (1000 + 8 * hv);
    hum_c = num / 100000;
    // effective window: zero acts as one, clamp at the limit
    w = win_cfg;
    if (w == 0) w = 1;
    if (w > longint'(htca_pkg::MAX_WINDOW)) w = longint'(htca_pkg::MAX_WINDOW);
    // sums wrap as 24 bit two's complement
    nt = acc_temp + temp_c[htca_pkg::SUM_W-1:0];
    nh = acc_hum + hum_c[htca_pkg::SUM_W-1:0];
    r.temp     = temp_c[htca_pkg::OUT_W-1:0];
    r.hum      = hum_c[htca_pkg::OUT_W-1:0];
    r.ready    = (longint'(n_samples) + 1) >= w;
    r.avg_temp = '0;
    r.avg_hum  = '0;
    if (r.ready) begin
      avg_t = longint'($signed(nt)) / w;
      avg_h = longint'($signed(nh)) / w;
      r.avg_temp = avg_t[htca_pkg::OUT_W-1:0];
      r.avg_hum  = avg_h[htca_pkg::OUT_W-1:0];
      acc_temp  = '0;
      acc_hum   = '0;
      n_samples = '0;
      windows_done++;
    end else begin
      acc_temp  = nt;
      acc_hum   = nh;
      n_samples = n_samples + 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting, one line each
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input hundredths_t got,
                                 input hundredths_t want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, $signed(got),
             $signed(want));
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // result monitor: every accepted result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch("result with nothing pending, temp", out_temp_hundredths, '0);
      end else begin
        want = expected_readings.pop_front();
        if (out_temp_hundredths !== want.temp)
          report_mismatch("temp_hundredths", out_temp_hundredths, want.temp);
        if (out_humidity_hundredths !== want.hum)
          report_mismatch("humidity_hundredths", out_humidity_hundredths, want.hum);
        if (out_average_ready !== want.ready)
          report_mismatch("average_ready", hundredths_t'(out_average_ready),
                          hundredths_t'(want.ready));
        if (out_avg_temp_hundredths !== want.avg_temp)
          report_mismatch("avg_temp_hundredths", out_avg_temp_hundredths, want.avg_temp);
        if (out_avg_humidity_hundredths !== want.avg_hum)
          report_mismatch("avg_humidity_hundredths", out_avg_humidity_hundredths,
                          want.avg_hum);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if neither channel moves a transaction for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, expected_readings.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern changes per segment; a requested hold-off overrides it
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic stall_next;
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen  = hold_req_cnt;
      hold_left  = HOLD_CYCLES - 1;
      stall_next = 1'b1;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 300);
      end
      seg_left--;
      case (rx_mode)
        RX_OPEN:   stall_next = 1'b0;
        RX_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
        RX_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
        default:   stall_next = seg_left[2];  // square wave from bit 2 of the segment counter
      endcase
    end
    out_stall <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one sample and hold it until the input transaction, then record its expectation
  task automatic send_reading(input raw_temp_t t, input raw_hum_t h, input logic typed,
                              input reading_t typed_want);
    reading_t predicted;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_raw_temp     <= t;
    in_raw_humidity <= h;
    do @(posedge clk); while (in_stall);
    // predictor runs for every sample so its state tracks typed rows too
    predicted = convert_and_average(t, h);
    expected_readings.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // drop valid and wait until every pending result has been taken
  task automatic wait_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  // window register write, only with the block idle
  task automatic write_window(input logic [htca_pkg::WIN_W-1:0] w);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    win_cfg = w;
    cfg_writes++;
  endtask

  // bursts of random length separated by gaps that are absent, short, medium or long
  task automatic pace_sender;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 4);
        2:       gap = $urandom_range(5, 40);
        default: gap = $urandom_range(41, 90);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic dir_row_t cfg_row(input logic [htca_pkg::WIN_W-1:0] w);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.win    = w;
    return r;
  endfunction

  function automatic dir_row_t sample_row(input raw_temp_t t, input raw_hum_t h);
    dir_row_t r;
    r   = '0;
    r.t = t;
    r.h = h;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input raw_temp_t t, input raw_hum_t h,
                                         input int et, input int eh, input logic er,
                                         input int eat, input int eah);
    dir_row_t r;
    r = sample_row(t, h);
    r.typed         = 1'b1;
    r.want.temp     = et[htca_pkg::OUT_W-1:0];
    r.want.hum      = eh[htca_pkg::OUT_W-1:0];
    r.want.ready    = er;
    r.want.avg_temp = eat[htca_pkg::OUT_W-1:0];
    r.want.avg_hum  = eah[htca_pkg::OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int        phase_win [NUM_PHASES];
    int        phase_len [NUM_PHASES];
    raw_temp_t t;
    raw_hum_t  h;

    phase_win = '{1, 4, 255, 0, 2, 13, 0};
    phase_len = '{60, 100, 280, 40, 100, 120, 130};
    phase_win[6] = $urandom_range(1, 254);

    // directed table
    // window 3 after reset: both corners, then a sample that closes the first window
    dir_rows.push_back(typed_row(14'd0, 12'd0, -3960, -464, 1'b0, 0, 0));
    dir_rows.push_back(typed_row(14'h3fff, 12'hfff, 12423, 14839, 1'b0, 0, 0));
    dir_rows.push_back(typed_row(14'd3960, 12'd0, 0, -425, 1'b1, 2821, 4650));
    // window of one: every sample reports itself as the average
    dir_rows.push_back(cfg_row(8'd1));
    dir_rows.push_back(typed_row(14'h3fff, 12'd0, 12423, -300, 1'b1, 12423, -300));
    dir_rows.push_back(typed_row(14'd0, 12'hfff, -3960, 9308, 1'b1, -3960, 9308));
    // window of zero acts as one
    dir_rows.push_back(cfg_row(8'd0));
    dir_rows.push_back(sample_row(14'd8191, 12'd2048));
    dir_rows.push_back(sample_row(14'd1, 12'd1));
    // largest window, partly filled
    dir_rows.push_back(cfg_row(8'd255));
    dir_rows.push_back(sample_row(14'h3fff, 12'hfff));
    dir_rows.push_back(sample_row(14'h3fff, 12'hfff));
    dir_rows.push_back(sample_row(14'h3fff, 12'hfff));
    dir_rows.push_back(sample_row(14'd12000, 12'd3000));
    dir_rows.push_back(sample_row(14'd5000, 12'd100));
    // window lowered below the running count: next sample closes it, average wraps
    dir_rows.push_back(cfg_row(8'd2));
    dir_rows.push_back(sample_row(14'd10000, 12'd2000));
    dir_rows.push_back(sample_row(14'd8192, 12'd2048));
    dir_rows.push_back(sample_row(14'h3fff, 12'hfff));
    // back to the reset window with alternating bit patterns
    dir_rows.push_back(cfg_row(8'd3));
    dir_rows.push_back(sample_row(14'h2aaa, 12'haaa));
    dir_rows.push_back(sample_row(14'h1555, 12'h555));
    dir_rows.push_back(sample_row(14'h2aaa, 12'h555));

    // predictor reset state
    win_cfg   = htca_pkg::WINDOW_RESET;
    acc_temp  = '0;
    acc_hum   = '0;
    n_samples = '0;

    // reset held low at the start, then released
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_window(dir_rows[i].win);
      else
        send_reading(dir_rows[i].t, dir_rows[i].h, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under its own window
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(phase_win[p][htca_pkg::WIN_W-1:0]);
      for (int n = 0; n < phase_len[p]; n++) begin
        // mostly uniform readings, now and then a corner value
        case ($urandom_range(0, 9))
          0:       t = '0;
          1:       t = '1;
          default: t = raw_temp_t'($urandom_range(0, (1 << htca_pkg::RAW_TEMP_W) - 1));
        endcase
        case ($urandom_range(0, 9))
          0:       h = '0;
          1:       h = '1;
          default: h = raw_hum_t'($urandom_range(0, (1 << htca_pkg::RAW_HUM_W) - 1));
        endcase
        // long receiver hold-off while the sender keeps offering samples
        if (p == 2 && n == 100) hold_req_cnt++;
        // sender pause until every pending result is out
        if (p == 4 && n == 50) wait_drained();
        send_reading(t, h, 1'b0, '0);
        pace_sender();
      end
    end

    // drain and let the block settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0)
      report_mismatch("results never produced, count",
                      hundredths_t'(expected_readings.size()), '0);

    $display("covered %0d samples and %0d results, %0d windows closed, %0d window writes",
             items_sent, results_seen, windows_done, cfg_writes);
    $display("windows 0, 1, 2, 3, 4, 13, 255 and %0d, plus a lowered window mid-block",
             phase_win[6]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/htca_pkg.sv
rtl/humidity_temp_convert_average.sv
tb/tb.sv
